// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge
`define FWPE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// cons must hold in the same cycle as ante
`define FWPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/fwpe_pkg.sv =====
package fwpe_pkg;

  // input kinds
  localparam logic [1:0] KIND_SEEK = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_FAIL = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_COUNT  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd1;
  localparam logic [1:0] CFG_RETAIN_FRAME = 2'd2;

  localparam logic [6:0] FRAME_COUNT_RST  = 7'd0;
  localparam logic [6:0] WINDOW_SIZE_RST  = 7'd20;
  localparam logic [6:0] RETAIN_FRAME_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_UNLOADED,
    ST_READING,
    ST_LOADED,
    ST_BAD
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_EVICT,
    ACT_PREFETCH,
    ACT_URGENT
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SETCUR,
    OP_SEEK,
    OP_TICK,
    OP_MARK
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEEK,
    S_EVICT,
    S_MOD,
    S_FWD_START,
    S_FWD,
    S_BWD_START,
    S_BWD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] frame;
    logic       prefetch_hold;
  } in_item_t;

  typedef struct packed {
    action_t    action;
    logic [5:0] frame_res;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [6:0] frame_count;
    logic [6:0] window_size;
    logic [6:0] retain_frame;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] frame;
    logic       hold;
    status_t    mark_st;
  } cmd_t;

endpackage

// ===== hw/rtl/fwpe_front.sv =====
module fwpe_front #(
  parameter int FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fwpe_pkg::in_item_t in_data,
  input  fwpe_pkg::cfg_t     cfg,
  output logic               cmd_valid,
  output fwpe_pkg::cmd_t     cmd,
  input  logic               cmd_pop,
  output logic [1:0]         q_count
);

  localparam logic [6:0] FRAMES_W = 7'(FRAMES);

  logic [6:0]     fc;
  fwpe_pkg::cmd_t cls;
  fwpe_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push, pop;

  // classify against the current config; the user must move config only while idle, the block does not enforce it
  always_comb begin
    fc          = (cfg.frame_count > FRAMES_W) ? FRAMES_W : cfg.frame_count;
    cls.op      = fwpe_pkg::OP_NONE;
    cls.frame   = in_data.frame;
    cls.hold    = in_data.prefetch_hold;
    cls.mark_st = (in_data.kind == fwpe_pkg::KIND_DONE) ? fwpe_pkg::ST_LOADED
                                                        : fwpe_pkg::ST_BAD;
    unique case (in_data.kind) inside
      fwpe_pkg::KIND_SEEK: begin
        if (fc <= 7'd1) begin
          cls.op = fwpe_pkg::OP_SETCUR;
        end else if ({1'b0, in_data.frame} < fc) begin
          cls.op = fwpe_pkg::OP_SEEK;
        end
      end
      fwpe_pkg::KIND_TICK: begin
        if (fc > 7'd1) begin
          cls.op = fwpe_pkg::OP_TICK;
        end
      end
      fwpe_pkg::KIND_DONE, fwpe_pkg::KIND_FAIL: begin
        if ({1'b0, in_data.frame} < FRAMES_W) begin
          cls.op = fwpe_pkg::OP_MARK;
        end
      end
    endcase
  end

  assign in_ready  = (count_r != 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign q_count   = count_r;
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hw/rtl/fwpe_back.sv =====
module fwpe_back #(
  parameter int FRAMES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fwpe_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  input  fwpe_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output fwpe_pkg::out_item_t out_data
);

  localparam int         AW       = $clog2(FRAMES);
  localparam logic [6:0] FRAMES_W = 7'(FRAMES);

  fwpe_pkg::state_t    state_r, state_nxt;
  fwpe_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [5:0]          cur_r, cur_nxt;
  logic [5:0]          start_r, start_nxt;
  logic [6:0]          a_r, a_nxt;
  logic [6:0]          ev_cnt_r, ev_cnt_nxt;
  logic [6:0]          m_r, m_nxt;
  logic [6:0]          idx_r, idx_nxt;
  logic signed [8:0]   ff_r, ff_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  fwpe_pkg::out_item_t pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  fwpe_pkg::out_item_t out_r, out_nxt;

  // status store: one write and one registered read per cycle
  fwpe_pkg::status_t   mem_r [FRAMES];
  logic [FRAMES-1:0]   vld_r;
  fwpe_pkg::status_t   rd_data_r;
  logic                rd_vld_r;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  fwpe_pkg::status_t   wr_data;

  fwpe_pkg::status_t   st;
  logic [6:0]          fc;
  logic [6:0]          ws;
  logic [8:0]          lim;
  logic signed [8:0]   lim_s, start_s;
  logic signed [8:0]   ev_d;
  logic                in_window, evict;
  logic [6:0]          a_plus, ev_cnt_after;
  logic signed [7:0]   seek_d;
  logic signed [8:0]   bwd_ff, fwd_step_ff, bwd_step_ff;
  logic [6:0]          bwd_idx, fwd_step_idx, bwd_step_idx;
  logic                can_emit, push_pend;

  always_comb begin
    st      = rd_vld_r ? rd_data_r : fwpe_pkg::ST_UNLOADED;
    fc      = (cfg.frame_count > FRAMES_W) ? FRAMES_W : cfg.frame_count;
    ws      = cfg.window_size;
    lim     = {3'b000, start_r} + {2'b00, ws};
    lim_s   = $signed(lim);
    start_s = $signed({3'b000, start_r});

    // window test for the eviction sweep, window wraps round the count
    ev_d = $signed({2'b00, a_r}) + $signed({2'b00, fc}) - start_s;
    if (a_r < {1'b0, start_r}) begin
      in_window = ev_d < $signed({2'b00, ws});
    end else begin
      in_window = {2'b00, a_r} < lim;
    end
    evict        = !in_window && (st == fwpe_pkg::ST_LOADED) && (a_r != cfg.retain_frame);
    a_plus       = a_r + 7'd1;
    ev_cnt_after = ev_cnt_r + {6'd0, evict};

    seek_d = $signed({2'b00, cmd_r.frame}) - $signed({2'b00, ws[6:1]});

    bwd_ff       = $signed({3'b000, cur_r}) - 9'sd1;
    bwd_idx      = (m_r == 7'd0) ? fc - 7'd1 : m_r - 7'd1;
    fwd_step_ff  = ff_r + 9'sd1;
    fwd_step_idx = (idx_r + 7'd1 == fc) ? 7'd0 : idx_r + 7'd1;
    bwd_step_ff  = ff_r - 9'sd1;
    bwd_step_idx = (idx_r == 7'd0) ? fc - 7'd1 : idx_r - 7'd1;
  end

  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    a_nxt          = a_r;
    ev_cnt_nxt     = ev_cnt_r;
    m_nxt          = m_r;
    idx_nxt        = idx_r;
    ff_nxt         = ff_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    cmd_pop        = 1'b0;
    push_pend      = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = fwpe_pkg::ST_UNLOADED;

    unique case (state_r)
      fwpe_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cmd_nxt        = cmd;
          pend_valid_nxt = 1'b0;
          ev_cnt_nxt     = 7'd0;
          m_nxt          = {1'b0, cur_r};
          unique case (cmd.op)
            fwpe_pkg::OP_SETCUR: begin
              cur_nxt   = cmd.frame;
              state_nxt = fwpe_pkg::S_FINISH;
            end
            fwpe_pkg::OP_SEEK: begin
              rd_en     = 1'b1;
              rd_addr   = cmd.frame[AW-1:0];
              state_nxt = fwpe_pkg::S_SEEK;
            end
            fwpe_pkg::OP_TICK: begin
              if (ws < fc) begin
                rd_en     = 1'b1;
                a_nxt     = 7'd0;
                state_nxt = fwpe_pkg::S_EVICT;
              end else begin
                state_nxt = cmd.hold ? fwpe_pkg::S_FINISH : fwpe_pkg::S_MOD;
              end
            end
            fwpe_pkg::OP_MARK: begin
              wr_en     = 1'b1;
              wr_addr   = cmd.frame[AW-1:0];
              wr_data   = cmd.mark_st;
              state_nxt = fwpe_pkg::S_FINISH;
            end
            default: begin
              state_nxt = fwpe_pkg::S_FINISH;
            end
          endcase
        end
      end

      fwpe_pkg::S_SEEK: begin
        cur_nxt   = cmd_r.frame;
        wr_addr   = cmd_r.frame[AW-1:0];
        state_nxt = fwpe_pkg::S_FINISH;
        // a bad frame leaves the window where it is
        if (st != fwpe_pkg::ST_BAD) begin
          start_nxt = (seek_d < 8'sd0) ? 6'd0 : seek_d[5:0];
        end
        if (st == fwpe_pkg::ST_UNLOADED) begin
          wr_en              = 1'b1;
          wr_data            = fwpe_pkg::ST_READING;
          pend_valid_nxt     = 1'b1;
          pend_nxt.action    = fwpe_pkg::ACT_URGENT;
          pend_nxt.frame_res = cmd_r.frame;
          pend_nxt.last      = 1'b1;
        end else if (st == fwpe_pkg::ST_READING) begin
          wr_en   = 1'b1;
          wr_data = fwpe_pkg::ST_LOADED;
        end
      end

      fwpe_pkg::S_EVICT: begin
        if (!(evict && pend_valid_r && !can_emit)) begin
          if (evict) begin
            wr_en              = 1'b1;
            wr_addr            = a_r[AW-1:0];
            wr_data            = fwpe_pkg::ST_UNLOADED;
            push_pend          = pend_valid_r;
            pend_valid_nxt     = 1'b1;
            pend_nxt.action    = fwpe_pkg::ACT_EVICT;
            pend_nxt.frame_res = a_r[5:0];
            pend_nxt.last      = 1'b1;
            ev_cnt_nxt         = ev_cnt_after;
          end
          if (a_plus < fc) begin
            rd_en   = 1'b1;
            rd_addr = a_plus[AW-1:0];
            a_nxt   = a_plus;
          end else if (cmd_r.hold || ev_cnt_after >= FRAMES_W) begin
            state_nxt = fwpe_pkg::S_FINISH;
          end else begin
            state_nxt = fwpe_pkg::S_MOD;
          end
        end
      end

      // current frame reduced modulo the count by repeated subtraction
      fwpe_pkg::S_MOD: begin
        if (m_r >= fc) begin
          m_nxt = m_r - fc;
        end else begin
          state_nxt = fwpe_pkg::S_FWD_START;
        end
      end

      fwpe_pkg::S_FWD_START: begin
        idx_nxt = m_r;
        ff_nxt  = $signed({3'b000, cur_r});
        if ($signed({3'b000, cur_r}) < lim_s) begin
          rd_en     = 1'b1;
          rd_addr   = m_r[AW-1:0];
          state_nxt = fwpe_pkg::S_FWD;
        end else begin
          state_nxt = fwpe_pkg::S_BWD_START;
        end
      end

      fwpe_pkg::S_BWD_START: begin
        idx_nxt = bwd_idx;
        ff_nxt  = bwd_ff;
        if (bwd_ff >= start_s) begin
          rd_en     = 1'b1;
          rd_addr   = bwd_idx[AW-1:0];
          state_nxt = fwpe_pkg::S_BWD;
        end else begin
          state_nxt = fwpe_pkg::S_FINISH;
        end
      end

      fwpe_pkg::S_FWD, fwpe_pkg::S_BWD: begin
        unique case (st) inside
          fwpe_pkg::ST_LOADED: begin
            if (state_r == fwpe_pkg::S_FWD) begin
              if (fwd_step_ff < lim_s) begin
                rd_en   = 1'b1;
                rd_addr = fwd_step_idx[AW-1:0];
                ff_nxt  = fwd_step_ff;
                idx_nxt = fwd_step_idx;
              end else begin
                state_nxt = fwpe_pkg::S_BWD_START;
              end
            end else begin
              if (bwd_step_ff >= start_s) begin
                rd_en   = 1'b1;
                rd_addr = bwd_step_idx[AW-1:0];
                ff_nxt  = bwd_step_ff;
                idx_nxt = bwd_step_idx;
              end else begin
                state_nxt = fwpe_pkg::S_FINISH;
              end
            end
          end
          fwpe_pkg::ST_UNLOADED: begin
            if (!(pend_valid_r && !can_emit)) begin
              wr_en              = 1'b1;
              wr_addr            = idx_r[AW-1:0];
              wr_data            = fwpe_pkg::ST_READING;
              push_pend          = pend_valid_r;
              pend_valid_nxt     = 1'b1;
              pend_nxt.action    = fwpe_pkg::ACT_PREFETCH;
              pend_nxt.frame_res = idx_r[5:0];
              pend_nxt.last      = 1'b1;
              state_nxt          = fwpe_pkg::S_FINISH;
            end
          end
          fwpe_pkg::ST_READING, fwpe_pkg::ST_BAD: begin
            state_nxt = fwpe_pkg::S_FINISH;
          end
        endcase
      end

      fwpe_pkg::S_FINISH: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt.action    = fwpe_pkg::ACT_NONE;
            out_nxt.frame_res = 6'd0;
          end
          out_nxt.last   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = fwpe_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fwpe_pkg::S_IDLE;
      end
    endcase

    // an earlier result goes out once a later one for the same item is known
    if (push_pend) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
      out_nxt.last  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fwpe_pkg::S_IDLE;
      cur_r        <= 6'd0;
      start_r      <= 6'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      start_r      <= start_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    a_r      <= a_nxt;
    ev_cnt_r <= ev_cnt_nxt;
    m_r      <= m_nxt;
    idx_r    <= idx_nxt;
    ff_r     <= ff_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  // entries never written read as unloaded through the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/frame_window_prefetch_evict_top.sv =====
// Frame residency tracker with windowed eviction and prefetch.
// Input channel (in_valid/in_ready/in_data): seek, tick, load completed or
// load failed items. Result channel (out_valid/out_ready/out_data): one or
// more actions per item, the final one flagged by last; an item with no
// action returns a single none result. Config port (cfg_we/cfg_index/
// cfg_wdata) sets frame count, window size and retained frame; write only
// when the block is idle.
// Items pass through a two-deep queue into a sequencer that owns the frame
// status memory; that memory has one read and one write port, so the
// sequencer visits one status entry per cycle unless a stalled receiver holds it.
// Events and out-of-range items go from idle through the finish state to the
// result register; seeks pass the seek state first. A tick sweeps all entries
// below frame_count for eviction if window size is below it, then, unless held,
// reduces the current frame modulo the count and probes forward then backward.
// Throughput: one item at a time; the next leaves the queue the cycle after
// the previous item's final result is registered.
// Reset: all frames read as unloaded at once (per-entry valid bits), no
// clearing pass; config returns to count 0, window 20, no retained frame.
// A stalled receiver holds the result register; further results of the
// same item wait, and the queue keeps taking items until it holds two.
`include "assert_macros.svh"

module frame_window_prefetch_evict_top #(
  parameter int FRAMES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fwpe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fwpe_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_wdata
);

  fwpe_pkg::cfg_t cfg_r, cfg_nxt;
  fwpe_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;
  logic [1:0]     q_count;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fwpe_pkg::CFG_FRAME_COUNT:  cfg_nxt.frame_count  = cfg_wdata;
        fwpe_pkg::CFG_WINDOW_SIZE:  cfg_nxt.window_size  = cfg_wdata;
        fwpe_pkg::CFG_RETAIN_FRAME: cfg_nxt.retain_frame = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count  <= fwpe_pkg::FRAME_COUNT_RST;
      cfg_r.window_size  <= fwpe_pkg::WINDOW_SIZE_RST;
      cfg_r.retain_frame <= fwpe_pkg::RETAIN_FRAME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fwpe_front #(
    .FRAMES(FRAMES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .q_count  (q_count)
  );

  fwpe_back #(
    .FRAMES(FRAMES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `FWPE_ASSERT(a_queue_bound, q_count <= 2'd2)
  `FWPE_ASSERT_IMP(a_full_blocks, q_count == 2'd2, !in_ready)
  // only evictions can be followed by another result of the same item
  `FWPE_ASSERT_IMP(a_mid_is_evict, out_valid && !out_data.last, out_data.action == fwpe_pkg::ACT_EVICT)
  `FWPE_ASSERT_IMP(a_none_alone, out_valid && out_data.action == fwpe_pkg::ACT_NONE, out_data.last && out_data.frame_res == 6'd0)

endmodule
